FILE: src/rtuvs_pkg.sv
`default_nettype none

package rtuvs_pkg;

	// excluded value table
	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned DATA_W = 32;

	// config port
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_RANGE_SIZE = 1'b0;

	// request kinds
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_FULL = 3'd1,
		STAT_RANGE = 3'd2,
		STAT_DUP = 3'd3,
		STAT_RANK = 3'd4
	} status_t;

	// shared unit: sum = a + b, compared against c
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [DATA_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic lt;
		logic eq;
	} alu_rsp_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t status;
	} result_t;

endpackage

`default_nettype wire

FILE: src/rtuvs_alu.sv
`default_nettype none

module rtuvs_alu (
	input rtuvs_pkg::alu_req_t req,
	output rtuvs_pkg::alu_rsp_t rsp
);
	import rtuvs_pkg::*;

	logic [DATA_W:0] sum;

	// 33 bit sum so that rank plus offset never wraps
	always_comb begin
		sum = {1'b0, req.a} + {{(DATA_W + 1 - CNT_W){1'b0}}, req.b};
		rsp.sum = sum[DATA_W-1:0];
		rsp.lt = sum < {1'b0, req.c};
		rsp.eq = sum == {1'b0, req.c};
	end

endmodule

`default_nettype wire

FILE: src/rtuvs_table.sv
`default_nettype none

module rtuvs_table (
	input logic clk,
	input rtuvs_pkg::tbl_wr_t wr,
	input logic [rtuvs_pkg::ADDR_W-1:0] raddr,
	output logic [rtuvs_pkg::DATA_W-1:0] rdata
);
	import rtuvs_pkg::*;

	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/rtuvs_seq.sv
`default_nettype none

module rtuvs_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic [rtuvs_pkg::DATA_W-1:0] operand,
	input logic [rtuvs_pkg::DATA_W-1:0] range_size,
	input logic out_free,
	output logic done,
	output rtuvs_pkg::result_t result,
	output rtuvs_pkg::alu_req_t alu_req,
	input rtuvs_pkg::alu_rsp_t alu_rsp,
	output rtuvs_pkg::tbl_wr_t tbl_wr,
	output logic [rtuvs_pkg::ADDR_W-1:0] tbl_raddr,
	input logic [rtuvs_pkg::DATA_W-1:0] tbl_rdata
);
	import rtuvs_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_SRCH = 8'b0000_0100,
		S_SCMP = 8'b0000_1000,
		S_DUPC = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_PLACE = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic pend_q, pend_d;
	logic is_query_q, is_query_d;
	logic [DATA_W-1:0] opnd_q, opnd_d;
	logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [ADDR_W-1:0] mid_q, mid_d, idx_q, idx_d, wa_q, wa_d;
	result_t res_q, res_d;

	logic [CNT_W-1:0] mid_w;
	logic full_w;
	logic go_right;

	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);
	assign full_w = count_q == CNT_W'(TABLE_DEPTH);
	assign in_ready = state_q == S_IDLE;
	assign result = res_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pend_d = pend_q;
		is_query_d = is_query_q;
		opnd_d = opnd_q;
		lo_d = lo_q;
		hi_d = hi_q;
		mid_d = mid_q;
		idx_d = idx_q;
		wa_d = wa_q;
		res_d = res_q;
		go_right = 1'b0;
		done = 1'b0;
		alu_req = '{a: opnd_q, b: CNT_W'(0), c: range_size};
		tbl_wr = '{we: 1'b0, addr: wa_q, data: tbl_rdata};
		tbl_raddr = mid_w[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					opnd_d = operand;
					res_d = '{value: '0, status: STAT_OK};
					unique case (req_type)
						REQ_CLEAR: begin
							count_d = '0;
							state_d = S_DONE;
						end
						REQ_INSERT: begin
							is_query_d = 1'b0;
							state_d = S_CHECK;
						end
						REQ_QUERY: begin
							is_query_d = 1'b1;
							state_d = S_CHECK;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			// insert: value < range; query: rank + count < range
			S_CHECK: begin
				alu_req = '{a: opnd_q, b: is_query_q ? count_q : CNT_W'(0), c: range_size};
				lo_d = '0;
				hi_d = count_q;
				if (!alu_rsp.lt) begin
					res_d.status = is_query_q ? STAT_RANK : STAT_RANGE;
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					tbl_raddr = mid_w[ADDR_W-1:0];
					mid_d = mid_w[ADDR_W-1:0];
					state_d = S_SCMP;
				end else if (is_query_q) begin
					alu_req = '{a: opnd_q, b: lo_q, c: range_size};
					res_d.value = alu_rsp.sum;
					state_d = S_DONE;
				end else if (lo_q < count_q) begin
					tbl_raddr = lo_q[ADDR_W-1:0];
					state_d = S_DUPC;
				end else if (full_w) begin
					res_d.status = STAT_FULL;
					state_d = S_DONE;
				end else begin
					idx_d = count_q[ADDR_W-1:0];
					pend_d = 1'b0;
					state_d = S_SHIFT;
				end
			end
			S_SCMP: begin
				if (is_query_q) begin
					// entry - mid <= rank  <=>  !(rank + mid < entry)
					alu_req = '{a: opnd_q, b: CNT_W'(mid_q), c: tbl_rdata};
					go_right = !alu_rsp.lt;
				end else begin
					alu_req = '{a: tbl_rdata, b: CNT_W'(0), c: opnd_q};
					go_right = alu_rsp.lt;
				end
				if (go_right) begin
					lo_d = CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					hi_d = CNT_W'(mid_q);
				end
				state_d = S_SRCH;
			end
			S_DUPC: begin
				alu_req = '{a: opnd_q, b: CNT_W'(0), c: tbl_rdata};
				if (alu_rsp.eq) begin
					res_d.status = STAT_DUP;
					state_d = S_DONE;
				end else if (full_w) begin
					res_d.status = STAT_FULL;
					state_d = S_DONE;
				end else begin
					idx_d = count_q[ADDR_W-1:0];
					pend_d = 1'b0;
					state_d = S_SHIFT;
				end
			end
			// read idx-1 while writing the entry read the cycle before
			S_SHIFT: begin
				tbl_wr = '{we: pend_q, addr: wa_q, data: tbl_rdata};
				if (idx_q != lo_q[ADDR_W-1:0]) begin
					tbl_raddr = idx_q - ADDR_W'(1);
					wa_d = idx_q;
					pend_d = 1'b1;
					idx_d = idx_q - ADDR_W'(1);
				end else begin
					pend_d = 1'b0;
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				tbl_wr = '{we: 1'b1, addr: lo_q[ADDR_W-1:0], data: opnd_q};
				count_d = count_q + CNT_W'(1);
				state_d = S_DONE;
			end
			S_DONE: begin
				done = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		is_query_q <= is_query_d;
		opnd_q <= opnd_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		mid_q <= mid_d;
		idx_q <= idx_d;
		wa_q <= wa_d;
		res_q <= res_d;
	end

endmodule

`default_nettype wire

FILE: src/rank_to_unblocked_value_search.sv
// Maps a rank to the rank-th value of 0 .. range_size-1 that is not in a sorted table of up to
// 64 excluded values (bad-block style skipping). Each input beat carries a request kind in
// s_axis_tuser (0 clear, 1 insert, 2 query, 3 no-op) and an operand in s_axis_tdata; every beat
// gives exactly one output beat with the value in m_axis_tdata and a status in m_axis_tuser
// (0 ok, 1 table full, 2 value out of range, 3 duplicate, 4 rank out of range). range_size is
// written over the APB port at address 0 and must only change while the block is idle. The
// block handles one beat at a time: s_axis_tready is low from acceptance until the result has
// been moved into the output register, which holds it while the next beat is taken. A clear or
// no-op goes straight to the result and an out-of-range request is rejected before the search.
// A query or insert runs up to s = ceil(log2(n + 1)) binary search steps, where n is the table
// fill; an insert that goes in at position p then shifts n - p entries up and writes the value.
// Each search step reads the table and then compares the entry, since the table has a
// registered read feeding one shared add/compare unit; the insert shift moves one entry per
// cycle, reading and writing the table through its separate read and write ports.
`default_nettype none

module rank_to_unblocked_value_search (
	input logic clk,
	input logic arst_n,
	// stream in
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [rtuvs_pkg::DATA_W-1:0] s_axis_tdata, // [31:0] operand
	input logic [1:0] s_axis_tuser, // [1:0] req_type
	// stream out
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [rtuvs_pkg::DATA_W-1:0] m_axis_tdata, // [31:0] result_value
	output logic [2:0] m_axis_tuser, // [2:0] status
	// config
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rtuvs_pkg::PADDR_W-1:0] paddr,
	input logic [rtuvs_pkg::DATA_W-1:0] pwdata,
	output logic [rtuvs_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import rtuvs_pkg::*;

	logic [DATA_W-1:0] range_size_q;
	logic m_valid_q;
	result_t m_res_q;

	logic out_free;
	logic done;
	result_t result;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	tbl_wr_t tbl_wr;
	logic [ADDR_W-1:0] tbl_raddr;
	logic [DATA_W-1:0] tbl_rdata;

	// register select is the word index; bits below it are byte offset
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_RANGE_SIZE) ? range_size_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_size_q <= DATA_W'(1);
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1] == REG_RANGE_SIZE) begin
			range_size_q <= pwdata;
		end
	end

	// sequencer: search, duplicate check, shift and result hand-off
	rtuvs_seq u_seq (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.req_type (s_axis_tuser),
		.operand (s_axis_tdata),
		.range_size (range_size_q),
		.out_free (out_free),
		.done (done),
		.result (result),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp),
		.tbl_wr (tbl_wr),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata)
	);

	// the one add/compare unit, shared by range checks, both searches and the answer
	rtuvs_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// sorted excluded values, only entries below the fill count are ever used
	rtuvs_table u_table (
		.clk (clk),
		.wr (tbl_wr),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// output register: takes a new result whenever it is empty or being drained
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_res_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_res_q.value;
	assign m_axis_tuser = m_res_q.status;

endmodule

`default_nettype wire

FILE: src/rtuvs_checker.sv
`default_nettype none

module rtuvs_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [rtuvs_pkg::DATA_W-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);
	import rtuvs_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// failed requests return zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
		else $error("nonzero value with error status");

	// one beat in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while busy");

	// a new result only comes from a beat in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while idle");

endmodule

bind rank_to_unblocked_value_search rtuvs_checker u_rtuvs_checker (.*);

`default_nettype wire

FILE: verif/rank_search_checker.sv
`timescale 1ns / 1ps

module rank_search_checker
	import rtuvs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [DATA_W-1:0] s_axis_tdata, // [31:0] operand
	input logic [1:0] s_axis_tuser, // [1:0] req_type
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata, // [31:0] result_value
	input logic [2:0] m_axis_tuser, // [2:0] status
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic pready,
	output int unsigned mismatches,
	output int unsigned pending
);

	logic [DATA_W-1:0] pick_range;
	logic [DATA_W-1:0] excluded [TABLE_DEPTH];
	int unsigned fill;
	result_t answers [$];

	// mirror of the block: sorted exclusion table plus rank lookup
	function automatic result_t predict_answer(input logic [1:0] kind,
		input logic [DATA_W-1:0] opnd);
		result_t ans;
		int unsigned pos;
		int unsigned i;
		logic [DATA_W-1:0] avail;
		logic [DATA_W-1:0] skipped;
		logic [DATA_W-1:0] slack;
		ans.value = '0;
		ans.status = STAT_OK;
		case (kind)
			REQ_CLEAR: begin
				fill = 0;
			end
			REQ_INSERT: begin
				pos = 0;
				while (pos < fill && excluded[pos] < opnd)
					pos++;
				if (opnd >= pick_range)
					ans.status = STAT_RANGE;
				else if (pos < fill && excluded[pos] == opnd)
					ans.status = STAT_DUP;
				else if (fill >= TABLE_DEPTH)
					ans.status = STAT_FULL;
				else begin
					for (i = fill; i > pos; i--)
						excluded[i] = excluded[i-1];
					excluded[pos] = opnd;
					fill++;
				end
			end
			REQ_QUERY: begin
				avail = (pick_range > DATA_W'(fill)) ? pick_range - DATA_W'(fill) : '0;
				if (opnd >= avail)
					ans.status = STAT_RANK;
				else begin
					// every entry whose slot-adjusted value is within the rank is skipped over
					skipped = '0;
					for (i = 0; i < fill; i++) begin
						slack = excluded[i] - DATA_W'(i);
						if (slack <= opnd)
							skipped++;
					end
					ans.value = opnd + skipped;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pick_range = 1;
			fill = 0;
			answers.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_RANGE_SIZE) begin
				if (pwrite)
					pick_range = pwdata;
				else if (prdata !== pick_range) begin
					$display("%0t: range_size read expected %h got %h", $time, pick_range,
						prdata);
					mismatches++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				answers.push_back(predict_answer(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers.size() == 0) begin
					$display("%0t: unexpected beat value %h status %0d", $time, m_axis_tdata,
						m_axis_tuser);
					mismatches++;
				end else begin
					want = answers.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
						$display("%0t: expected value %h status %0d, got value %h status %0d",
							$time, want.value, want.status, m_axis_tdata, m_axis_tuser);
						mismatches++;
					end
				end
			end
			pending = answers.size();
		end
	end

endmodule

FILE: verif/tb_rank_to_unblocked_value_search.sv
`timescale 1ns / 1ps

module tb_rank_to_unblocked_value_search;
	import rtuvs_pkg::*;

	// kind with no function in the block
	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_RANGE_SIZE = {REG_RANGE_SIZE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = {~REG_RANGE_SIZE, 2'b00};
	// worst case: ~600 beats, long front inserts, long random gaps on both sides
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// longest single request plus output register
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned ITEMS_PER_PHASE = 110;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0; // [31:0] operand
	logic [1:0] s_axis_tuser = REQ_CLEAR; // [1:0] req_type
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata; // [31:0] result_value
	logic [2:0] m_axis_tuser; // [2:0] status
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	// range as last written, used only to aim operands at the edges and within the range
	logic [DATA_W-1:0] cur_range = 1;

	rank_to_unblocked_value_search u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	rank_search_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one request beat, with random idle cycles ahead of it
	task automatic send_req(input logic [1:0] kind, input logic [DATA_W-1:0] opnd);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= opnd;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// hold the sender until every answer is back and the block has gone quiet
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
		input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_range(input logic [DATA_W-1:0] value);
		apb_access(1'b1, ADDR_RANGE_SIZE, value);
		cur_range = value;
	endtask

	// operands clustered at the range edges, with some fully random ones
	function automatic logic [DATA_W-1:0] pick_operand(input logic [1:0] kind);
		int unsigned sel;
		sel = $urandom_range(9);
		case (sel)
			0: return $urandom();
			1: return (kind == REQ_INSERT) ? cur_range + $urandom_range(3)
				: cur_range - $urandom_range(70);
			2: return cur_range - 1;
			3: return '0;
			default: return $urandom_range(cur_range - 1, 0);
		endcase
	endfunction

	task automatic random_req();
		int unsigned roll;
		logic [1:0] kind;
		roll = $urandom_range(99);
		if (roll < 5)
			kind = REQ_CLEAR;
		else if (roll < 9)
			kind = REQ_NOP;
		else if (roll < 55)
			kind = REQ_INSERT;
		else
			kind = REQ_QUERY;
		send_req(kind, pick_operand(kind));
	endtask

	initial begin
		int unsigned n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest range: only rank 0 exists until value 0 is excluded
		set_range(1);
		send_req(REQ_QUERY, 0);
		send_req(REQ_QUERY, 1);
		send_req(REQ_INSERT, 0);
		send_req(REQ_INSERT, 1);
		send_req(REQ_QUERY, 0);
		send_req(REQ_INSERT, 0);
		send_req(REQ_NOP, 32'hFFFF_FFFF);
		send_req(REQ_CLEAR, 32'hFFFF_FFFF);
		send_req(REQ_QUERY, 0);
		drain();

		// largest range, exclusions at both ends
		set_range(32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'hFFFF_FFFE);
		send_req(REQ_INSERT, 0);
		send_req(REQ_INSERT, 5);
		send_req(REQ_QUERY, 0);
		send_req(REQ_QUERY, 32'hFFFF_FFFC);
		send_req(REQ_QUERY, 32'hFFFF_FFFB);
		send_req(REQ_INSERT, 32'hFFFF_FFFF);
		send_req(REQ_QUERY, 32'hFFFF_FFFF);
		drain();

		// range shrunk under existing entries, including two beyond the new end
		set_range(4);
		apb_access(1'b1, ADDR_UNUSED, 32'h0000_0123);
		apb_access(1'b0, ADDR_RANGE_SIZE, '0);
		send_req(REQ_QUERY, 0);
		send_req(REQ_QUERY, 1);
		send_req(REQ_INSERT, 3);
		send_req(REQ_QUERY, 0);
		send_req(REQ_CLEAR, 0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					set_range(1000);
					// fill the table past its depth, then probe it
					send_req(REQ_CLEAR, $urandom());
					for (n = 0; n < 72; n++)
						send_req(REQ_INSERT, $urandom_range(999));
				end
				1: begin
					idle_pct = 51;
					stall_pct = 0;
					set_range(32'hFFFF_FFFF);
				end
				2: begin
					idle_pct = 0;
					stall_pct = 51;
					set_range(40);
				end
				default: begin
					idle_pct = 16;
					stall_pct = 16;
					set_range($urandom_range(300, 64));
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				random_req();
			drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
